// ===== hdl/amp_pkg.sv =====
// shared constants and types for the average / max pooling block
package amp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_WINDOW  = 7;
    localparam int MAX_PLANES  = 1024;
    localparam int MAX_RESULTS = 16;

    localparam int PIX_W     = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int WIN_W     = 3;
    localparam int OCOL_W    = 8;
    localparam int OPLANE_W  = 10;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W   = COL_W + 1;
    localparam int POS_W   = DIM_W + 1;
    localparam int PLANE_W = $clog2(MAX_PLANES);
    localparam int PCNT_W  = PLANE_W + 1;
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_RESULTS);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_WINDOW;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int SUM_W  = PIX_W + $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int MAG_W  = SUM_W - 1;
    localparam int DIV_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int DCNT_W = $clog2(MAG_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_COUNT,
        CFG_WINDOW,
        CFG_STEP,
        CFG_MODE
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_DRAIN,
        S_POST,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ===== hdl/avg_max_pool_window_core.sv =====
// streaming 2-d average / max pooling core over raster-order feature planes
//
// Pixels enter one per transfer, column fastest, then row, then plane. Each
// pixel is written into a row store of MAX_WINDOW rows and the block then
// emits every pooling window whose clipped bottom-right corner is that pixel
// (up to 16), in row-major order of the output grid, tagged with output
// column, row and plane; last marks the final result of the pixel. Windows
// are re-read from the row store, one value per cycle through the single
// read port. A pixel that completes no window leaves the block idle; the
// input stalls while windows are worked on. Average mode adds a restoring
// divide per window, and any output stall holds the block. Averages are the
// clipped sum divided by window_size squared, truncated toward zero.
// Known register writes restart the layer at plane 0, row 0, column 0; zero
// sizes act as one and oversize values saturate. No clearing pass is needed.
module avg_max_pool_window_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [amp_pkg::PIX_W-1:0]     pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [amp_pkg::PIX_W-1:0]     pooled,
    output logic [amp_pkg::OCOL_W-1:0]    out_col,
    output logic [amp_pkg::OCOL_W-1:0]    out_row,
    output logic [amp_pkg::OPLANE_W-1:0]  out_plane,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [amp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [amp_pkg::CFG_W-1:0]     cfg_data
);

    import amp_pkg::*;

    // configuration
    logic [DIM_W-1:0]  plane_width_reg, plane_height_reg;
    logic [CFG_W-1:0]  plane_count_reg;
    logic [WIN_W-1:0]  window_size_reg, step_size_reg;
    logic              pool_mode_reg;

    // effective sizes after zero / saturation handling
    logic [DIM_W-1:0]  w_c, h_c;
    logic [PCNT_W-1:0] np_c;
    logic [WIN_W-1:0]  fs_c, st_c, half_c, e_c;
    logic [DIV_W-1:0]  divisor_c;

    // stream position and stride phase trackers
    logic [COL_W-1:0]   cx_reg, cy_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [WIN_W-1:0]   xrem_reg, yrem_reg;
    logic [COL_W-1:0]   xk_reg, yk_reg;
    logic [POS_W-1:0]   xpos_reg, ypos_reg;

    // window enumeration for the pixel being worked on
    logic [POS_W-1:0]   wxs_pos_reg, wx_pos_reg, wy_pos_reg;
    logic [COL_W-1:0]   wxs_k_reg, wx_k_reg, wy_k_reg;
    logic               lastcol_reg, lastrow_reg;
    logic [COL_W-1:0]   bx_reg, by_reg;
    logic [SLOT_W-1:0]  bslot_reg;
    logic [PLANE_W-1:0] bplane_reg;
    logic [CNT_W-1:0]   wcnt_reg;

    // window sweep
    logic [COL_W-1:0]   x0_reg, rx_reg, ry_reg;
    logic [SLOT_W-1:0]  rslot_reg;
    logic               rd_valid_reg, first_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [PIX_W-1:0] max_reg;

    // divider
    logic [MAG_W-1:0]   dq_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               neg_reg;
    logic [PIX_W-1:0]   result_reg;

    // output register
    logic               out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]   out_pooled_reg;
    logic [OCOL_W-1:0]  out_col_reg, out_row_reg;
    logic [OPLANE_W-1:0] out_plane_reg;

    state_t state_reg, state_next;

    // ram ports
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr, ram_waddr;
    logic [PIX_W-1:0]  ram_rdata;

    // helpers
    logic              in_acc, cfg_acc, out_load, has_next, x_more, y_more;
    logic              lastcol_c, lastrow_c, x_any, y_any;
    logic [POS_W-1:0]  xs_pos_c, ys_pos_c;
    logic [COL_W-1:0]  xs_k_c, ys_k_c;
    logic              read_end;
    logic [COL_W-1:0]  x0_c, y0_c;
    logic [SLOT_W-1:0] d_c, rslot_c, slot_inc, rslot_inc;
    logic [DIV_W:0]    div_t;
    logic [MAG_W-1:0]  dq_step;
    logic [DIV_W-1:0]  rem_step;
    logic signed [PIX_W-1:0] rd_pix;

    amp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (ram_waddr),
        .wdata (pixel),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective configuration
    always_comb
    begin
        if (plane_width_reg == '0)
            w_c = DIM_W'(1);
        else if (plane_width_reg > DIM_W'(MAX_WIDTH))
            w_c = DIM_W'(MAX_WIDTH);
        else
            w_c = plane_width_reg;
        if (plane_height_reg == '0)
            h_c = DIM_W'(1);
        else if (plane_height_reg > DIM_W'(MAX_WIDTH))
            h_c = DIM_W'(MAX_WIDTH);
        else
            h_c = plane_height_reg;
        if (plane_count_reg == '0)
            np_c = PCNT_W'(1);
        else if (CFG_W'(plane_count_reg) > CFG_W'(MAX_PLANES))
            np_c = PCNT_W'(MAX_PLANES);
        else
            np_c = PCNT_W'(plane_count_reg);
        if (window_size_reg == '0)
            fs_c = WIN_W'(1);
        else if (window_size_reg > WIN_W'(MAX_WINDOW))
            fs_c = WIN_W'(MAX_WINDOW);
        else
            fs_c = window_size_reg;
        st_c      = (step_size_reg == '0) ? WIN_W'(1) : step_size_reg;
        half_c    = (fs_c - WIN_W'(1)) >> 1;
        e_c       = fs_c - WIN_W'(1) - half_c;
        divisor_c = DIV_W'(fs_c) * DIV_W'(fs_c);
    end

    // handshakes and window enumeration
    always_comb
    begin
        in_acc   = in_valid && !in_stall;
        cfg_acc  = cfg_valid && cfg_ready;
        out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

        // first window ending at this column / row, if any
        lastcol_c = (DIM_W'(cx_reg) + DIM_W'(1)) == w_c;
        lastrow_c = (DIM_W'(cy_reg) + DIM_W'(1)) == h_c;
        if (cx_reg < COL_W'(e_c))
        begin
            xs_pos_c = '0;
            xs_k_c   = '0;
        end
        else
        begin
            xs_pos_c = xpos_reg + ((xrem_reg != '0) ? POS_W'(st_c) : '0);
            xs_k_c   = xk_reg + ((xrem_reg != '0) ? COL_W'(1) : '0);
        end
        if (cy_reg < COL_W'(e_c))
        begin
            ys_pos_c = '0;
            ys_k_c   = '0;
        end
        else
        begin
            ys_pos_c = ypos_reg + ((yrem_reg != '0) ? POS_W'(st_c) : '0);
            ys_k_c   = yk_reg + ((yrem_reg != '0) ? COL_W'(1) : '0);
        end
        x_any = lastcol_c ? (xs_pos_c < POS_W'(w_c))
                          : ((cx_reg >= COL_W'(e_c)) && (xrem_reg == '0));
        y_any = lastrow_c ? (ys_pos_c < POS_W'(h_c))
                          : ((cy_reg >= COL_W'(e_c)) && (yrem_reg == '0));

        // further windows for this pixel
        x_more   = lastcol_reg && ((wx_pos_reg + POS_W'(st_c)) < POS_W'(w_c));
        y_more   = lastrow_reg && ((wy_pos_reg + POS_W'(st_c)) < POS_W'(h_c));
        has_next = (wcnt_reg != CNT_W'(MAX_RESULTS - 1)) && (x_more || y_more);

        // clipped window origin and its row slot
        x0_c = (wx_pos_reg >= POS_W'(half_c)) ? COL_W'(wx_pos_reg - POS_W'(half_c)) : '0;
        y0_c = (wy_pos_reg >= POS_W'(half_c)) ? COL_W'(wy_pos_reg - POS_W'(half_c)) : '0;
        d_c  = SLOT_W'(by_reg - y0_c);
        rslot_c = (bslot_reg >= d_c) ? (bslot_reg - d_c)
                                     : SLOT_W'(SLOT_W'(MAX_WINDOW) + bslot_reg - d_c);

        slot_inc  = (slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
        rslot_inc = (rslot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0 : rslot_reg + SLOT_W'(1);
        read_end  = (rx_reg == bx_reg) && (ry_reg == by_reg);

        // one restoring divide step
        div_t = {rem_reg, dq_reg[MAG_W-1]};
        if (div_t >= (DIV_W+1)'(divisor_c))
        begin
            rem_step = DIV_W'(div_t - (DIV_W+1)'(divisor_c));
            dq_step  = {dq_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_step = DIV_W'(div_t);
            dq_step  = {dq_reg[MAG_W-2:0], 1'b0};
        end

        rd_pix = ram_rdata;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc && x_any && y_any) state_next = S_SETUP;
            S_SETUP: state_next = S_READ;
            S_READ:  if (read_end) state_next = S_DRAIN;
            S_DRAIN: state_next = S_POST;
            S_POST:  state_next = pool_mode_reg ? S_OUT : S_DIV;
            S_DIV:   if (dcnt_reg == DCNT_W'(1)) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = has_next ? S_SETUP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        cfg_ready = 1'b1;
        ram_re    = (state_reg == S_READ);
        ram_raddr = ADDR_W'(rslot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx_reg);
        ram_waddr = ADDR_W'(slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx_reg);
        out_valid = out_valid_reg;
        pooled    = out_pooled_reg;
        out_col   = out_col_reg;
        out_row   = out_row_reg;
        out_plane = out_plane_reg;
        last      = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= DIM_W'(1);
            plane_height_reg <= DIM_W'(1);
            plane_count_reg  <= CFG_W'(1);
            window_size_reg  <= WIN_W'(2);
            step_size_reg    <= WIN_W'(2);
            pool_mode_reg    <= 1'b1;
            cx_reg    <= '0;
            cy_reg    <= '0;
            plane_reg <= '0;
            slot_reg  <= '0;
            xrem_reg  <= '0;
            xk_reg    <= '0;
            xpos_reg  <= '0;
            yrem_reg  <= '0;
            yk_reg    <= '0;
            ypos_reg  <= '0;
        end
        else if (cfg_acc)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  plane_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: plane_height_reg <= cfg_data[DIM_W-1:0];
                CFG_COUNT:  plane_count_reg  <= cfg_data;
                CFG_WINDOW: window_size_reg  <= cfg_data[WIN_W-1:0];
                CFG_STEP:   step_size_reg    <= cfg_data[WIN_W-1:0];
                CFG_MODE:   pool_mode_reg    <= cfg_data[0];
                default:    ;
            endcase
            // any known register restarts the layer
            if (cfg_index <= CFG_IDX_W'(CFG_MODE))
            begin
                cx_reg    <= '0;
                cy_reg    <= '0;
                plane_reg <= '0;
                slot_reg  <= '0;
                xrem_reg  <= '0;
                xk_reg    <= '0;
                xpos_reg  <= '0;
                yrem_reg  <= '0;
                yk_reg    <= '0;
                ypos_reg  <= '0;
            end
        end
        else if (in_acc)
        begin
            if (lastcol_c)
            begin
                cx_reg   <= '0;
                xrem_reg <= '0;
                xk_reg   <= '0;
                xpos_reg <= '0;
                if (lastrow_c)
                begin
                    cy_reg   <= '0;
                    slot_reg <= '0;
                    yrem_reg <= '0;
                    yk_reg   <= '0;
                    ypos_reg <= '0;
                    if ((PCNT_W'(plane_reg) + PCNT_W'(1)) >= np_c)
                        plane_reg <= '0;
                    else
                        plane_reg <= plane_reg + PLANE_W'(1);
                end
                else
                begin
                    cy_reg   <= cy_reg + COL_W'(1);
                    slot_reg <= slot_inc;
                    if (cy_reg >= COL_W'(e_c))
                    begin
                        if (yrem_reg + WIN_W'(1) == st_c)
                        begin
                            yrem_reg <= '0;
                            yk_reg   <= yk_reg + COL_W'(1);
                            ypos_reg <= ypos_reg + POS_W'(st_c);
                        end
                        else
                        begin
                            yrem_reg <= yrem_reg + WIN_W'(1);
                        end
                    end
                end
            end
            else
            begin
                cx_reg <= cx_reg + COL_W'(1);
                if (cx_reg >= COL_W'(e_c))
                begin
                    if (xrem_reg + WIN_W'(1) == st_c)
                    begin
                        xrem_reg <= '0;
                        xk_reg   <= xk_reg + COL_W'(1);
                        xpos_reg <= xpos_reg + POS_W'(st_c);
                    end
                    else
                    begin
                        xrem_reg <= xrem_reg + WIN_W'(1);
                    end
                end
            end
        end
    end

    // window sweep, reduction and divide
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                // latch the window list of the accepted pixel
                wxs_pos_reg <= xs_pos_c;
                wxs_k_reg   <= xs_k_c;
                wx_pos_reg  <= xs_pos_c;
                wx_k_reg    <= xs_k_c;
                wy_pos_reg  <= ys_pos_c;
                wy_k_reg    <= ys_k_c;
                lastcol_reg <= lastcol_c;
                lastrow_reg <= lastrow_c;
                bx_reg      <= cx_reg;
                by_reg      <= cy_reg;
                bslot_reg   <= slot_reg;
                bplane_reg  <= plane_reg;
                wcnt_reg    <= '0;
            end
            S_SETUP:
            begin
                x0_reg    <= x0_c;
                rx_reg    <= x0_c;
                ry_reg    <= y0_c;
                rslot_reg <= rslot_c;
                first_reg <= 1'b1;
            end
            S_READ:
            begin
                if (rx_reg == bx_reg)
                begin
                    rx_reg    <= x0_reg;
                    ry_reg    <= ry_reg + COL_W'(1);
                    rslot_reg <= rslot_inc;
                end
                else
                begin
                    rx_reg <= rx_reg + COL_W'(1);
                end
            end
            S_DRAIN: ;
            S_POST:
            begin
                result_reg <= max_reg;
                neg_reg    <= sum_reg[SUM_W-1];
                dq_reg     <= sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
                rem_reg    <= '0;
                dcnt_reg   <= DCNT_W'(MAG_W);
            end
            S_DIV:
            begin
                dq_reg     <= dq_step;
                rem_reg    <= rem_step;
                dcnt_reg   <= dcnt_reg - DCNT_W'(1);
                result_reg <= neg_reg ? PIX_W'(-dq_step) : PIX_W'(dq_step);
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    wcnt_reg <= wcnt_reg + CNT_W'(1);
                    if (x_more)
                    begin
                        wx_pos_reg <= wx_pos_reg + POS_W'(st_c);
                        wx_k_reg   <= wx_k_reg + COL_W'(1);
                    end
                    else
                    begin
                        wy_pos_reg <= wy_pos_reg + POS_W'(st_c);
                        wy_k_reg   <= wy_k_reg + COL_W'(1);
                        wx_pos_reg <= wxs_pos_reg;
                        wx_k_reg   <= wxs_k_reg;
                    end
                end
            end
            default: ;
        endcase

        // read data lands in the cycle after the address
        if (rd_valid_reg)
        begin
            first_reg <= 1'b0;
            if (first_reg)
            begin
                sum_reg <= SUM_W'(rd_pix);
                max_reg <= rd_pix;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(rd_pix);
                if (rd_pix > max_reg)
                    max_reg <= rd_pix;
            end
        end

        if (out_load)
        begin
            out_pooled_reg <= result_reg;
            out_col_reg    <= wx_k_reg;
            out_row_reg    <= wy_k_reg;
            out_plane_reg  <= bplane_reg;
            out_last_reg   <= !has_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == S_READ);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // read data only returns while a window is being swept
    a_rd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_DRAIN || state_reg == S_READ))
        else $error("read data outside a window sweep");

    // the divider only runs in average mode
    a_div_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !pool_mode_reg)
        else $error("divider active in max mode");

    // a result marked last returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !has_next) |=> (state_reg == S_IDLE))
        else $error("block busy after last result");

    // a transfer is taken only in idle and leaves idle only when windows exist
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !(x_any && y_any)) |=> (state_reg == S_IDLE))
        else $error("pixel without windows did not return to idle");

endmodule

// ===== hdl/amp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module amp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
